[rtl/idca_pkg.sv]
package idca_pkg;

  // field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned SEC_W   = 23;

  // packed stream widths (padded to whole bytes)
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 40;

  // configuration register indexes
  localparam logic [1:0] REG_ON_SECONDS     = 2'd0;
  localparam logic [1:0] REG_PERIOD_SECONDS = 2'd1;
  localparam logic [1:0] REG_MIN_OUTPUT     = 2'd2;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK       = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_TARGET = 2'd1;
  localparam logic [OP_W-1:0] OP_SET_ENABLE = 2'd2;

  // time scale and period limit
  localparam logic [TIME_W-1:0] MS_PER_SECOND  = 32'd1000;
  localparam logic [SEC_W-1:0]  MAX_PERIOD_SEC = 23'd4294967;

endpackage

[rtl/interval_duty_cycle_actuator.sv]
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+--------------------------------------
// in       | slave     | in_tvalid / in_tready      | tuser: operation; tdata: now_ms,
//          |           |                            |   target_value, enable_request
// out      | master    | out_tvalid / out_tready    | tdata: drive_write, drive_value,
//          |           |                            |   enabled_now, in_on_phase
// cfg      | slave     | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// a tick latches the item and the period scaled to milliseconds, runs the bit-serial
// remainder unit over all 32 dividend bits, then finishes; target and enable operations
// go straight to the finish step. one item is in work at a time. reset (rst_n,
// synchronous, active low) clears state, config (period to one second) and the output
// valid flag. a result waits in the output register under out_tready stall while the
// next item is already taken; the finish step holds only if that register is still full.
module interval_duty_cycle_actuator (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [idca_pkg::OP_W-1:0]       in_tuser,   // [1:0] operation
  input  logic [idca_pkg::IN_DATA_W-1:0]  in_tdata,   // [31:0] now_ms, [63:32] target_value,
                                                      // [64] enable_request, rest zero
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [idca_pkg::OUT_DATA_W-1:0] out_tdata,  // [0] drive_write, [32:1] drive_value,
                                                      // [33] enabled_now, [34] in_on_phase
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [idca_pkg::VALUE_W-1:0]    cfg_data
);

  localparam int unsigned DIV_STEPS = idca_pkg::TIME_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t state_r;

  // configuration registers
  logic [idca_pkg::SEC_W-1:0]   on_sec_r;
  logic [idca_pkg::SEC_W-1:0]   period_sec_r;
  logic [idca_pkg::VALUE_W-1:0] min_output_r;

  // block state
  logic [idca_pkg::TIME_W-1:0]  cycle_start_r;
  logic                         started_r;
  logic                         on_phase_r;
  logic [idca_pkg::VALUE_W-1:0] stored_target_r;
  logic                         enabled_r;

  // work registers
  logic                         tick_r;
  logic                         pend_wr_r;
  logic [idca_pkg::VALUE_W-1:0] pend_val_r;
  logic [idca_pkg::TIME_W-1:0]  period_ms_r;
  logic [idca_pkg::TIME_W-1:0]  on_ms_r;
  logic [idca_pkg::TIME_W-1:0]  dividend_r;
  logic [idca_pkg::TIME_W-1:0]  rem_r;
  logic [idca_pkg::TIME_W-1:0]  rem_nxt;
  logic [CNT_W-1:0]             cnt_r;

  // output stage
  logic                          out_valid_r;
  logic [idca_pkg::OUT_DATA_W-1:0] out_data_r;

  // input fields
  logic [idca_pkg::OP_W-1:0]    in_op;
  logic [idca_pkg::TIME_W-1:0]  in_now;
  logic [idca_pkg::VALUE_W-1:0] in_target;
  logic                         in_enable;
  logic                         in_fire;

  // effective period and on-time
  logic [idca_pkg::SEC_W-1:0]   eff_period;
  logic [idca_pkg::SEC_W-1:0]   eff_on;
  logic [idca_pkg::TIME_W-1:0]  period_ms_nxt;
  logic [idca_pkg::TIME_W-1:0]  on_ms_nxt;
  logic [idca_pkg::TIME_W:0]    trial;
  logic                         phase_now;
  logic                         out_free;
  logic                         en_restart;

  assign in_op     = in_tuser;
  assign in_now    = in_tdata[31:0];
  assign in_target = in_tdata[63:32];
  assign in_enable = in_tdata[64];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // rising enable with nonzero on-time restarts the cycle
  assign en_restart = in_enable && !enabled_r && (eff_on != '0);

  // clamp period and on-time, scale to milliseconds
  always_comb begin
    if (period_sec_r == '0) begin
      eff_period = idca_pkg::SEC_W'(1);
    end else if (period_sec_r > idca_pkg::MAX_PERIOD_SEC) begin
      eff_period = idca_pkg::MAX_PERIOD_SEC;
    end else begin
      eff_period = period_sec_r;
    end
    eff_on        = (on_sec_r > eff_period) ? eff_period : on_sec_r;
    period_ms_nxt = idca_pkg::TIME_W'(eff_period) * idca_pkg::MS_PER_SECOND;
    on_ms_nxt     = idca_pkg::TIME_W'(eff_on) * idca_pkg::MS_PER_SECOND;
  end

  // one restoring remainder step per cycle, dividend bits enter msb first
  always_comb begin
    trial = {rem_r, dividend_r[idca_pkg::TIME_W-1]} - {1'b0, period_ms_r};
    if (trial[idca_pkg::TIME_W]) begin
      rem_nxt = {rem_r[idca_pkg::TIME_W-2:0], dividend_r[idca_pkg::TIME_W-1]};
    end else begin
      rem_nxt = trial[idca_pkg::TIME_W-1:0];
    end
  end

  assign phase_now = (rem_r < on_ms_r);

  // control, state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      on_sec_r        <= '0;
      period_sec_r    <= idca_pkg::SEC_W'(1);
      min_output_r    <= '0;
      cycle_start_r   <= '0;
      started_r       <= 1'b0;
      on_phase_r      <= 1'b0;
      stored_target_r <= '0;
      enabled_r       <= 1'b0;
      out_valid_r     <= 1'b0;
      cnt_r           <= '0;
    end else begin
      // configuration transfer
      if (cfg_valid) begin
        case (cfg_index)
          idca_pkg::REG_ON_SECONDS:     on_sec_r     <= cfg_data[idca_pkg::SEC_W-1:0];
          idca_pkg::REG_PERIOD_SECONDS: period_sec_r <= cfg_data[idca_pkg::SEC_W-1:0];
          idca_pkg::REG_MIN_OUTPUT:     min_output_r <= cfg_data;
          default: ;
        endcase
      end

      // result taken downstream with no new one loaded behind it
      if (out_valid_r && out_tready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            tick_r <= (in_op == idca_pkg::OP_TICK);
            case (in_op)
              idca_pkg::OP_TICK: begin
                // latch cycle start on the first tick
                if (!started_r) begin
                  cycle_start_r <= in_now;
                  started_r     <= 1'b1;
                  dividend_r    <= '0;
                end else begin
                  dividend_r    <= in_now - cycle_start_r;
                end
                pend_wr_r   <= 1'b0;
                pend_val_r  <= '0;
                period_ms_r <= period_ms_nxt;
                on_ms_r     <= on_ms_nxt;
                rem_r       <= '0;
                cnt_r       <= CNT_W'(DIV_STEPS - 1);
                state_r     <= ST_DIV;
              end
              idca_pkg::OP_SET_TARGET: begin
                stored_target_r <= in_target;
                pend_wr_r       <= on_phase_r;
                pend_val_r      <= on_phase_r ? in_target : '0;
                state_r         <= ST_FIN;
              end
              idca_pkg::OP_SET_ENABLE: begin
                enabled_r  <= in_enable;
                pend_wr_r  <= en_restart;
                pend_val_r <= en_restart ? stored_target_r : '0;
                state_r    <= ST_FIN;
                if (en_restart) begin
                  cycle_start_r <= in_now;
                  started_r     <= 1'b1;
                  on_phase_r    <= 1'b1;
                end
              end
              default: begin
                pend_wr_r  <= 1'b0;
                pend_val_r <= '0;
                state_r    <= ST_FIN;
              end
            endcase
          end
        end

        ST_DIV: begin
          rem_r      <= rem_nxt;
          dividend_r <= {dividend_r[idca_pkg::TIME_W-2:0], 1'b0};
          cnt_r      <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= ST_FIN;
          end
        end

        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
            if (tick_r) begin
              // phase change issues a drive value
              on_phase_r <= phase_now;
              if (phase_now != on_phase_r) begin
                out_data_r <= {5'b0, phase_now, enabled_r,
                               (phase_now ? stored_target_r : min_output_r), 1'b1};
              end else begin
                out_data_r <= {5'b0, phase_now, enabled_r, {idca_pkg::VALUE_W{1'b0}}, 1'b0};
              end
            end else begin
              out_data_r <= {5'b0, on_phase_r, enabled_r, pend_val_r, pend_wr_r};
            end
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // remainder stays below the divisor while the unit runs
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < period_ms_r))
    else $error("remainder not below period");

  // on window never exceeds the period
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (on_ms_r <= period_ms_r))
    else $error("on window longer than period");

  // no drive means a zero drive value
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r[0]) |-> (out_data_r[32:1] == '0))
    else $error("drive value without drive write");

  // an accepted item blocks the next one in the cycle after it
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("second item taken while one is in work");

endmodule

[verif/interval_duty_cycle_actuator_tb.sv]
module interval_duty_cycle_actuator_tb;

  localparam int CLK_PERIOD = 12;
  localparam int LIMIT_CYCLES = 1_200_000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [idca_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic                          drive_write;
    logic [idca_pkg::VALUE_W-1:0]  drive_value;
    logic                          enabled_now;
    logic                          in_on_phase;
  } drive_result_t;

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [idca_pkg::OP_W-1:0]       in_tuser = '0;
  logic [idca_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [idca_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [1:0]                      cfg_index = '0;
  logic [idca_pkg::VALUE_W-1:0]    cfg_data = '0;

  // shadow of the gate: configuration and state
  logic [idca_pkg::SEC_W-1:0]   reg_on_s = '0;
  logic [idca_pkg::SEC_W-1:0]   reg_period_s = 23'd1;
  logic [idca_pkg::VALUE_W-1:0] reg_min = '0;
  logic [idca_pkg::TIME_W-1:0]  gate_start_ms = '0;
  logic                         gate_started = 1'b0;
  logic                         gate_on = 1'b0;
  logic [idca_pkg::VALUE_W-1:0] gate_target = '0;
  logic                         gate_enabled = 1'b0;

  drive_result_t               pending_drives[$];
  logic [idca_pkg::TIME_W-1:0] time_cursor;
  int                          idle_pct = 0;
  int                          stall_left = 0;
  int                          errors = 0;
  int                          n_items = 0;
  int                          n_results = 0;
  int                          n_drives = 0;
  int                          n_settings = 0;

  interval_duty_cycle_actuator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("interval_duty_cycle_actuator_tb: FAIL");
    $finish;
  end

  // effective period and on-time after clamping
  function automatic logic [idca_pkg::SEC_W-1:0] eff_period_s();
    logic [idca_pkg::SEC_W-1:0] p;
    p = reg_period_s;
    if (p == '0) p = 23'd1;
    if (p > idca_pkg::MAX_PERIOD_SEC) p = idca_pkg::MAX_PERIOD_SEC;
    return p;
  endfunction

  function automatic logic [idca_pkg::SEC_W-1:0] eff_on_s();
    logic [idca_pkg::SEC_W-1:0] p;
    p = eff_period_s();
    return (reg_on_s > p) ? p : reg_on_s;
  endfunction

  function automatic logic [idca_pkg::TIME_W-1:0] period_ms();
    return {9'd0, eff_period_s()} * idca_pkg::MS_PER_SECOND;
  endfunction

  // next result of the gate for one item, state updated in place
  function automatic drive_result_t compute_drive(input logic [idca_pkg::OP_W-1:0] op,
                                                  input logic [idca_pkg::TIME_W-1:0] now,
                                                  input logic [idca_pkg::VALUE_W-1:0] tv,
                                                  input logic req);
    drive_result_t r;
    logic [idca_pkg::TIME_W-1:0] elapsed;
    logic ph;
    logic was;
    r = '0;
    case (op)
      idca_pkg::OP_TICK: begin
        if (!gate_started) begin
          gate_start_ms = now;
          gate_started = 1'b1;
        end
        elapsed = (now - gate_start_ms) % period_ms();
        ph = elapsed < ({9'd0, eff_on_s()} * idca_pkg::MS_PER_SECOND);
        if (ph != gate_on) begin
          gate_on = ph;
          r.drive_write = 1'b1;
          r.drive_value = ph ? gate_target : reg_min;
        end
      end
      idca_pkg::OP_SET_TARGET: begin
        gate_target = tv;
        if (gate_on) begin
          r.drive_write = 1'b1;
          r.drive_value = tv;
        end
      end
      idca_pkg::OP_SET_ENABLE: begin
        was = gate_enabled;
        gate_enabled = req;
        if (req && !was && eff_on_s() != '0) begin
          gate_start_ms = now;
          gate_started = 1'b1;
          gate_on = 1'b1;
          r.drive_write = 1'b1;
          r.drive_value = gate_target;
        end
      end
      default: ;
    endcase
    r.enabled_now = gate_enabled;
    r.in_on_phase = gate_on;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      errors++;
    end
  endfunction

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= (stall_left == 0);
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(1, 19);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each result transfer with the oldest expected drive
  always @(posedge clk) begin
    drive_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (pending_drives.size() == 0) begin
        $error("result transfer with nothing expected: 0x%010h", out_tdata);
        errors++;
      end else begin
        want = pending_drives.pop_front();
        if (want.drive_write) n_drives++;
        check_field("drive_write", 32'(want.drive_write), 32'(out_tdata[0]));
        check_field("drive_value", want.drive_value, out_tdata[32:1]);
        check_field("enabled_now", 32'(want.enabled_now), 32'(out_tdata[33]));
        check_field("in_on_phase", 32'(want.in_on_phase), 32'(out_tdata[34]));
        check_field("tdata padding", 32'd0, 32'(out_tdata[idca_pkg::OUT_DATA_W-1:35]));
      end
    end
  end

  // one item transfer; tvalid stays high into the next item unless a gap comes
  task automatic send_item(input logic [idca_pkg::OP_W-1:0] op,
                           input logic [idca_pkg::TIME_W-1:0] now,
                           input logic [idca_pkg::VALUE_W-1:0] tv, input logic req);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, req, tv, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_drives.push_back(compute_drive(op, now, tv, req));
    n_items++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [idca_pkg::VALUE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      idca_pkg::REG_ON_SECONDS:     reg_on_s = data[idca_pkg::SEC_W-1:0];
      idca_pkg::REG_PERIOD_SECONDS: reg_period_s = data[idca_pkg::SEC_W-1:0];
      idca_pkg::REG_MIN_OUTPUT:     reg_min = data;
      default: ;
    endcase
  endtask

  // all three registers, written only with the gate idle; junk above bit 22 is dropped
  task automatic set_config(input logic [idca_pkg::SEC_W-1:0] on_s,
                            input logic [idca_pkg::SEC_W-1:0] per_s,
                            input logic [idca_pkg::VALUE_W-1:0] min_v);
    logic [8:0] junk_a;
    logic [8:0] junk_b;
    junk_a = 9'($urandom);
    junk_b = 9'($urandom);
    drain();
    write_reg(idca_pkg::REG_ON_SECONDS, {junk_a, on_s});
    write_reg(idca_pkg::REG_PERIOD_SECONDS, {junk_b, per_s});
    write_reg(idca_pkg::REG_MIN_OUTPUT, min_v);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic pick_random_config();
    logic [idca_pkg::SEC_W-1:0] per_s;
    logic [idca_pkg::SEC_W-1:0] on_s;
    case ($urandom_range(0, 7))
      0: begin
        per_s = '0;
        on_s = idca_pkg::SEC_W'($urandom_range(0, 2));
      end
      5: begin
        per_s = idca_pkg::SEC_W'($urandom_range(7, 4294967));
        on_s = idca_pkg::SEC_W'($urandom_range(0, per_s));
      end
      6: begin
        per_s = idca_pkg::SEC_W'($urandom_range(4294968, 8388607));
        on_s = idca_pkg::SEC_W'($urandom);
      end
      7: begin
        per_s = idca_pkg::SEC_W'($urandom_range(1, 10));
        on_s = idca_pkg::SEC_W'($urandom);
      end
      default: begin
        per_s = idca_pkg::SEC_W'($urandom_range(1, 6));
        on_s = idca_pkg::SEC_W'($urandom_range(0, per_s + 1));
      end
    endcase
    set_config(on_s, per_s, $urandom);
  endtask

  // timestamps mostly advance by fractions of the period so both windows get hit
  task automatic run_timeline(input int count);
    logic [idca_pkg::TIME_W-1:0] advance;
    int sel;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 6) advance = $urandom;
      else advance = $urandom_range(0, period_ms() / 3 + 1);
      time_cursor += advance;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        send_item(idca_pkg::OP_TICK, time_cursor, $urandom, 1'($urandom_range(0, 1)));
      end else if (sel < 82) begin
        send_item(idca_pkg::OP_SET_TARGET, time_cursor, $urandom, 1'($urandom_range(0, 1)));
      end else if (sel < 94) begin
        send_item(idca_pkg::OP_SET_ENABLE, time_cursor, $urandom, 1'($urandom_range(0, 1)));
      end else if (sel < 97) begin
        send_item(OP_UNUSED, $urandom, $urandom, 1'($urandom_range(0, 1)));
      end else begin
        send_item(idca_pkg::OP_TICK, $urandom, $urandom, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_directed_cases();
    logic [idca_pkg::TIME_W-1:0] base;
    base = 32'hFFFF_FC18;
    // reset config: on-time zero, one-second period
    send_item(OP_UNUSED, '1, '1, 1'b1);
    send_item(idca_pkg::OP_SET_ENABLE, 32'h10, '0, 1'b1);
    send_item(idca_pkg::OP_TICK, 32'h100, '0, 1'b0);
    // two seconds on out of five, near the timestamp wrap
    set_config(23'd2, 23'd5, 32'h8000_0000);
    send_item(idca_pkg::OP_SET_ENABLE, base, '0, 1'b0);
    send_item(idca_pkg::OP_SET_TARGET, base, 32'h7FFF_FFFF, 1'b0);
    send_item(idca_pkg::OP_SET_ENABLE, base, '0, 1'b1);
    send_item(idca_pkg::OP_SET_ENABLE, base + 1, '0, 1'b1);
    send_item(idca_pkg::OP_TICK, base + 1999, '0, 1'b0);
    send_item(idca_pkg::OP_TICK, base + 2000, '0, 1'b0);
    send_item(idca_pkg::OP_SET_TARGET, base, 32'h8000_0000, 1'b0);
    send_item(idca_pkg::OP_TICK, base + 5000, '0, 1'b0);
    send_item(idca_pkg::OP_SET_TARGET, base, 32'h0000_0001, 1'b0);
    send_item(idca_pkg::OP_TICK, base - 1, '0, 1'b0);
    // zero period and zero on-time
    set_config(23'd0, 23'd0, 32'h7FFF_FFFF);
    send_item(idca_pkg::OP_SET_ENABLE, base, '0, 1'b0);
    send_item(idca_pkg::OP_SET_ENABLE, base, '0, 1'b1);
    send_item(idca_pkg::OP_TICK, 32'hFFFF_FFFF, '0, 1'b0);
    // period saturated, on-time above period
    set_config(23'h7F_FFFF, 23'h7F_FFFF, 32'h0);
    send_item(idca_pkg::OP_TICK, 32'h0, '0, 1'b0);
    send_item(idca_pkg::OP_TICK, 32'hFFFF_FFFF, '0, 1'b0);
    set_config(23'd3, 23'h7F_FFFF, 32'h8000_0000);
    send_item(idca_pkg::OP_TICK, $urandom, '0, 1'b0);
    send_item(idca_pkg::OP_SET_TARGET, '0, 32'hFFFF_FFFF, 1'b1);
    send_item(idca_pkg::OP_SET_ENABLE, '0, 32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_random_schedules(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      pick_random_config();
      idle_pct = 8 * $urandom_range(0, 3);
      run_timeline(per_phase);
    end
  endtask

  task automatic test_back_to_back(input int phases, input int per_phase);
    idle_pct = 0;
    for (int p = 0; p < phases; p++) begin
      pick_random_config();
      run_timeline(per_phase);
    end
  endtask

  initial begin
    time_cursor = $urandom;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_schedules(16, 100);
    test_back_to_back(3, 110);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items over %0d register settings with random stalls on both sides",
             n_items, n_settings);
    $display("checked %0d results, %0d of them carrying a drive value", n_results, n_drives);
    if (errors == 0) begin
      $display("interval_duty_cycle_actuator_tb: PASS");
    end else begin
      $display("interval_duty_cycle_actuator_tb: FAIL");
    end
    $finish;
  end

endmodule
